/* design/agsc_pkg.sv */
package agsc_pkg;

  // fixed number formats
  localparam int FRAC_BITS        = 8;
  localparam int MAX_TILE_SHIFT   = 8;
  localparam int CW               = 32;
  localparam int SHIFT_W          = 5;
  localparam int STEP_SHIFT       = 6;
  localparam int FRAC_SCALE_SHIFT = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 10;
  localparam int OB_W             = 80;

  localparam logic signed [CW-1:0] COORD_MAX = 32'sd8388607;
  localparam logic signed [CW-1:0] COORD_MIN = -32'sd8388608;

  typedef enum logic [1:0] {
    OP_TILE  = 2'd0,
    OP_OBST  = 2'd1,
    OP_COUNT = 2'd2,
    OP_MOVE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_TILE_SHIFT  = 2'd0,
    CFG_ASSIST_EN   = 2'd1,
    CFG_ASSIST_FRAC = 2'd2
  } cfg_e;

  // probe steps of one move
  typedef enum logic [7:0] {
    S_RX  = 8'b0000_0001,
    S_RY  = 8'b0000_0010,
    S_A1  = 8'b0000_0100,
    S_A2  = 8'b0000_1000,
    S_PY  = 8'b0001_0000,
    S_PX2 = 8'b0010_0000,
    S_PX  = 8'b0100_0000,
    S_PY2 = 8'b1000_0000
  } step_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic [11:0]        cell_index;
    logic               cell_blocked;
    logic [3:0]         obstacle_slot;
    logic [4:0]         obstacle_count_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic               hit_x;
    logic               hit_y;
  } out_item_t;

  typedef struct packed {
    logic  accept;
    logic  clear;
    logic  setup;
    logic  ginit;
    logic  gbase;
    logic  grid_hit;
    logic  cell_next;
    logic  ob_start;
    logic  ob_next;
    logic  ob_chk;
    logic  commit;
    logic  push_next;
    logic  load_out;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dzero;
    logic empty;
    logic outside;
    logic cell_blk;
    logic cell_last;
    logic ob_none;
    logic ob_last;
    logic hit;
    logic assist_go;
    logic neg;
    logic horiz;
  } sts_t;

  // clamp to the signed 24 bit coordinate range
  function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX;
    end else if (v < COORD_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v;
    end
    return r[23:0];
  endfunction

endpackage

/* design/agsc_ram.sv */
module agsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/agsc_ctrl.sv */
module agsc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  agsc_pkg::sts_t sts_i,
  output agsc_pkg::cmd_t cmd_o
);
  import agsc_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_SETUP  = 12'b0000_0000_0100,
    ST_GINIT  = 12'b0000_0000_1000,
    ST_GBASE  = 12'b0000_0001_0000,
    ST_GRD    = 12'b0000_0010_0000,
    ST_GCK    = 12'b0000_0100_0000,
    ST_ORD    = 12'b0000_1000_0000,
    ST_OCK    = 12'b0001_0000_0000,
    ST_NEXT   = 12'b0010_0000_0000,
    ST_ASSIST = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd         = '0;
    cmd.step    = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          if (op_e'(op_i) == OP_MOVE) begin
            step_d  = S_RX;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_d   = sts_i.dzero ? ST_NEXT : ST_GINIT;
      end
      ST_GINIT: begin
        cmd.ginit = 1'b1;
        state_d   = ST_GBASE;
      end
      ST_GBASE: begin
        if (sts_i.empty || sts_i.outside) begin
          cmd.grid_hit = sts_i.outside & ~sts_i.empty;
          cmd.ob_start = 1'b1;
          state_d      = sts_i.ob_none ? ST_NEXT : ST_ORD;
        end else begin
          cmd.gbase = 1'b1;
          state_d   = ST_GRD;
        end
      end
      ST_GRD: begin
        state_d = ST_GCK;
      end
      ST_GCK: begin
        if (sts_i.cell_blk || sts_i.cell_last) begin
          cmd.grid_hit = sts_i.cell_blk;
          cmd.ob_start = 1'b1;
          state_d      = sts_i.ob_none ? ST_NEXT : ST_ORD;
        end else begin
          cmd.cell_next = 1'b1;
          state_d       = ST_GRD;
        end
      end
      ST_ORD: begin
        state_d = ST_OCK;
      end
      ST_OCK: begin
        cmd.ob_chk = 1'b1;
        if (sts_i.ob_last) begin
          state_d = ST_NEXT;
        end else begin
          cmd.ob_next = 1'b1;
          state_d     = ST_ORD;
        end
      end
      ST_NEXT: begin
        cmd.commit = 1'b1;
        unique case (step_q)
          S_RX: begin
            step_d  = S_RY;
            state_d = ST_SETUP;
          end
          S_RY: begin
            state_d = ST_ASSIST;
          end
          S_A1, S_A2: begin
            if (!sts_i.hit && step_q == S_A1) begin
              step_d  = S_A2;
              state_d = ST_SETUP;
            end else if (!sts_i.hit) begin
              step_d  = sts_i.horiz ? S_PY : S_PX;
              state_d = ST_SETUP;
            end else begin
              // push failed: try the other sign, then a larger push
              cmd.push_next = 1'b1;
              if (sts_i.neg) begin
                state_d = ST_ASSIST;
              end else begin
                step_d  = S_A1;
                state_d = ST_SETUP;
              end
            end
          end
          S_PY: begin
            step_d  = S_PX2;
            state_d = ST_SETUP;
          end
          S_PX: begin
            step_d  = S_PY2;
            state_d = ST_SETUP;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_ASSIST: begin
        if (sts_i.assist_go) begin
          step_d  = S_A1;
          state_d = ST_SETUP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= S_RX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* design/agsc_dp.sv */
module agsc_dp #(
  parameter int MAP_W         = 64,
  parameter int MAP_H         = 64,
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  agsc_pkg::in_item_t                  in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [agsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [agsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  agsc_pkg::cmd_t                      cmd_i,
  output agsc_pkg::sts_t                      sts_o,
  output agsc_pkg::out_item_t                 out_data_o
);
  import agsc_pkg::*;

  localparam int CELLS  = MAP_W * MAP_H;
  localparam int MAP_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CX_W   = (MAP_W > 1) ? $clog2(MAP_W) : 1;
  localparam int CY_W   = (MAP_H > 1) ? $clog2(MAP_H) : 1;
  localparam int OB_D   = (MAX_OBSTACLES > 0) ? MAX_OBSTACLES : 1;
  localparam int OB_AW  = (OB_D > 1) ? $clog2(OB_D) : 1;
  localparam int CNT_W  = (MAX_OBSTACLES > 0) ? $clog2(MAX_OBSTACLES + 1) : 1;
  localparam logic signed [CW-1:0] MAP_W_C = CW'(MAP_W);
  localparam logic signed [CW-1:0] MAP_H_C = CW'(MAP_H);

  // configuration and table state
  logic [3:0]        ts_q;
  logic              ae_q;
  logic [9:0]        af_q;
  logic [MAP_AW-1:0] clr_q;
  logic [CNT_W-1:0]  cnt_q;

  // move item
  logic signed [23:0] x_q, y_q;
  logic [15:0]        w_q, h_q;
  logic signed [15:0] dx_q, dy_q;
  logic signed [CW-1:0] xe, ye, we, he, dxe, dye;

  // results so far
  logic signed [CW-1:0] nx_q, ny_q;
  logic                 hx_q, hy_q;

  // probe registers
  logic signed [CW-1:0] prx_q, pry_q, best_q, snap_q;
  logic                 axy_q, dpos_q, hit_q;
  logic signed [CW-1:0] cx0_q, cx1_q, cy0_q, cy1_q;
  logic [CX_W-1:0]      cx_q;
  logic [CY_W-1:0]      cy_q;
  logic [MAP_AW-1:0]    row_q;
  logic [OB_AW-1:0]     oi_q;

  // corner search
  logic signed [CW-1:0] mag_q;
  logic                 neg_q;

  out_item_t out_q;

  // derived tile geometry
  logic [3:0]           ts_eff;
  logic [SHIFT_W-1:0]   s;
  logic signed [CW-1:0] tile, mask, step_sz, lim_raw, lim_p1, push;

  assign ts_eff  = (ts_q > 4'(MAX_TILE_SHIFT)) ? 4'(MAX_TILE_SHIFT) : ts_q;
  assign s       = SHIFT_W'(ts_eff) + SHIFT_W'(FRAC_BITS);
  assign tile    = CW'(1) << s;
  assign mask    = tile - CW'(1);
  assign step_sz = CW'(1) << (s - SHIFT_W'(STEP_SHIFT));
  assign lim_raw = CW'(af_q) << s;
  assign lim_p1  = (lim_raw >>> FRAC_SCALE_SHIFT) + CW'(1);
  assign push    = neg_q ? -mag_q : mag_q;

  assign xe  = CW'(x_q);
  assign ye  = CW'(y_q);
  assign we  = CW'(w_q);
  assign he  = CW'(h_q);
  assign dxe = CW'(dx_q);
  assign dye = CW'(dy_q);

  // memories
  logic              map_we, map_wdata, map_rdata;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic              ob_we;
  logic [OB_W-1:0]   ob_wdata, ob_rdata;
  logic              is_tile, is_obst, is_count, is_move;

  assign is_tile  = cmd_i.accept && (op_e'(in_data_i.opcode) == OP_TILE);
  assign is_obst  = cmd_i.accept && (op_e'(in_data_i.opcode) == OP_OBST);
  assign is_count = cmd_i.accept && (op_e'(in_data_i.opcode) == OP_COUNT);
  assign is_move  = cmd_i.accept && (op_e'(in_data_i.opcode) == OP_MOVE);

  assign map_we    = cmd_i.clear |
                     (is_tile && (32'(in_data_i.cell_index) < 32'(CELLS)));
  assign map_waddr = cmd_i.clear ? clr_q : MAP_AW'(in_data_i.cell_index);
  assign map_wdata = cmd_i.clear ? 1'b0 : in_data_i.cell_blocked;
  assign map_raddr = row_q + MAP_AW'(cx_q);

  assign ob_we    = is_obst && (32'(in_data_i.obstacle_slot) < 32'(MAX_OBSTACLES));
  assign ob_wdata = {in_data_i.box_x, in_data_i.box_y, in_data_i.box_w, in_data_i.box_h};

  agsc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  agsc_ram #(.WIDTH(OB_W), .DEPTH(OB_D)) u_obst (
    .clk_i   (clk_i),
    .we_i    (ob_we),
    .waddr_i (OB_AW'(in_data_i.obstacle_slot)),
    .wdata_i (ob_wdata),
    .raddr_i (oi_q),
    .rdata_o (ob_rdata)
  );

  // probe position for each step
  logic signed [CW-1:0] su_px, su_py;
  logic                 su_axy, su_dpos;
  logic                 hcond, vcond;

  assign hcond = (dx_q != '0) && (dy_q == '0) && hx_q;
  assign vcond = (dy_q != '0) && (dx_q == '0) && hy_q;

  always_comb begin
    su_px   = xe;
    su_py   = ye;
    su_axy  = 1'b0;
    su_dpos = 1'b1;
    unique case (cmd_i.step)
      S_RX: begin
        su_px   = xe + dxe;
        su_dpos = (dx_q > 0);
      end
      S_RY: begin
        su_px   = nx_q;
        su_py   = ye + dye;
        su_axy  = 1'b1;
        su_dpos = (dy_q > 0);
      end
      S_A1: begin
        if (hcond) begin
          su_py = ye + push;
        end else begin
          su_px = xe + push;
        end
      end
      S_A2: begin
        if (hcond) begin
          su_px = xe + dxe;
          su_py = ye + push;
        end else begin
          su_px = xe + push;
          su_py = ye + dye;
        end
      end
      S_PY: begin
        su_py   = ye + push;
        su_axy  = 1'b1;
        su_dpos = ~neg_q;
      end
      S_PX2: begin
        su_px   = xe + dxe;
        su_py   = ny_q;
        su_dpos = (dx_q > 0);
      end
      S_PX: begin
        su_px   = xe + push;
        su_dpos = ~neg_q;
      end
      S_PY2: begin
        su_px   = nx_q;
        su_py   = ye + dye;
        su_axy  = 1'b1;
        su_dpos = (dy_q > 0);
      end
      default: begin
        su_px = xe;
      end
    endcase
  end

  // grid bounds and wall snap
  logic signed [CW-1:0] sz, pos, ex, ey, ea;
  assign sz  = axy_q ? he : we;
  assign pos = axy_q ? pry_q : prx_q;
  assign ex  = prx_q + we - CW'(1);
  assign ey  = pry_q + he - CW'(1);
  assign ea  = pos + sz - CW'(1);

  // obstacle overlap and candidate edge
  logic signed [23:0]   ox24, oy24;
  logic signed [CW-1:0] oxe, oye, owe, ohe, oa, osz, cand;
  logic                 overlap, better;

  assign ox24 = ob_rdata[79:56];
  assign oy24 = ob_rdata[55:32];
  assign oxe  = CW'(ox24);
  assign oye  = CW'(oy24);
  assign owe  = CW'(ob_rdata[31:16]);
  assign ohe  = CW'(ob_rdata[15:0]);
  assign oa   = axy_q ? oye : oxe;
  assign osz  = axy_q ? ohe : owe;
  assign cand = dpos_q ? (oa - sz) : (oa + osz);
  assign better  = dpos_q ? (cand < best_q) : (cand > best_q);
  assign overlap = (prx_q < oxe + owe) && (prx_q + we > oxe) &&
                   (pry_q < oye + ohe) && (pry_q + he > oye);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= 4'd4;
      ae_q  <= 1'b0;
      af_q  <= '0;
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_TILE_SHIFT:  ts_q <= cfg_data_i[3:0];
          CFG_ASSIST_EN:   ae_q <= cfg_data_i[0];
          CFG_ASSIST_FRAC: af_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (is_count) begin
        cnt_q <= (32'(in_data_i.obstacle_count_in) > 32'(MAX_OBSTACLES)) ?
                 CNT_W'(MAX_OBSTACLES) : CNT_W'(in_data_i.obstacle_count_in);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (is_move) begin
      x_q  <= in_data_i.box_x;
      y_q  <= in_data_i.box_y;
      w_q  <= in_data_i.box_w;
      h_q  <= in_data_i.box_h;
      dx_q <= in_data_i.move_dx;
      dy_q <= in_data_i.move_dy;
    end
    if (cmd_i.setup) begin
      prx_q  <= su_px;
      pry_q  <= su_py;
      axy_q  <= su_axy;
      dpos_q <= su_dpos;
      best_q <= su_axy ? su_py : su_px;
      hit_q  <= 1'b0;
    end
    if (cmd_i.ginit) begin
      cx0_q  <= prx_q >>> s;
      cy0_q  <= pry_q >>> s;
      cx1_q  <= ex >>> s;
      cy1_q  <= ey >>> s;
      snap_q <= dpos_q ? ((ea & ~mask) - sz) : ((pos & ~mask) + tile);
    end
    if (cmd_i.gbase) begin
      cx_q  <= cx0_q[CX_W-1:0];
      cy_q  <= cy0_q[CY_W-1:0];
      row_q <= MAP_AW'(cy0_q[CY_W-1:0] * MAP_W);
    end
    if (cmd_i.cell_next) begin
      if (cx_q == cx1_q[CX_W-1:0]) begin
        cx_q  <= cx0_q[CX_W-1:0];
        cy_q  <= cy_q + 1'b1;
        row_q <= row_q + MAP_AW'(MAP_W);
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end
    if (cmd_i.ob_start) begin
      oi_q <= '0;
    end
    if (cmd_i.ob_next) begin
      oi_q <= oi_q + 1'b1;
    end
    // wall snap first, obstacle edges after it
    if (cmd_i.grid_hit) begin
      hit_q  <= 1'b1;
      best_q <= snap_q;
    end
    if (cmd_i.ob_chk && overlap) begin
      hit_q <= 1'b1;
      if (!hit_q || better) begin
        best_q <= cand;
      end
    end
    if (cmd_i.commit) begin
      unique case (cmd_i.step)
        S_RX: begin
          nx_q <= best_q;
          hx_q <= hit_q;
        end
        S_RY: begin
          ny_q  <= best_q;
          hy_q  <= hit_q;
          mag_q <= step_sz;
          neg_q <= 1'b0;
        end
        S_PY: ny_q <= best_q;
        S_PX: nx_q <= best_q;
        S_PX2: begin
          nx_q <= best_q;
          hx_q <= hit_q;
          hy_q <= 1'b0;
        end
        S_PY2: begin
          ny_q <= best_q;
          hy_q <= hit_q;
          hx_q <= 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd_i.push_next) begin
      if (neg_q) begin
        neg_q <= 1'b0;
        mag_q <= mag_q + step_sz;
      end else begin
        neg_q <= 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      out_q.new_x <= sat24(nx_q);
      out_q.new_y <= sat24(ny_q);
      out_q.hit_x <= hx_q;
      out_q.hit_y <= hy_q;
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.clr_last  = (clr_q == MAP_AW'(CELLS - 1));
    sts_o.dzero     = ((cmd_i.step == S_RX) && (dx_q == '0)) ||
                      ((cmd_i.step == S_RY) && (dy_q == '0));
    sts_o.empty     = (cx1_q < cx0_q) || (cy1_q < cy0_q);
    sts_o.outside   = (cx0_q < 0) || (cy0_q < 0) || (cx1_q >= MAP_W_C) ||
                      (cy1_q >= MAP_H_C);
    sts_o.cell_blk  = map_rdata;
    sts_o.cell_last = (cx_q == cx1_q[CX_W-1:0]) && (cy_q == cy1_q[CY_W-1:0]);
    sts_o.ob_none   = (cnt_q == '0);
    sts_o.ob_last   = (({1'b0, oi_q} + 1'b1) == (OB_AW + 1)'(cnt_q));
    sts_o.hit       = hit_q;
    sts_o.assist_go = ae_q && (af_q != '0) && (hcond || vcond) && (mag_q <= lim_p1);
    sts_o.neg       = neg_q;
    sts_o.horiz     = hcond;
  end

  assign out_data_o = out_q;

endmodule

/* design/aabb_grid_slide_collision.sv */
// operation: tile, obstacle and count writes are taken in idle, a move takes two probes,
// two more once a corner push is found, the corner search one or two per tried push sign;
// a probe runs setup, grid init, grid base, a read and a check per tile scanned, a read and
// a check per obstacle in use, and commit; the first two skip to commit with zero motion
// throughput: one transaction at a time, the next accepted once the move has finished
// reset: the tile map is swept clear cell by cell before the first transaction
module aabb_grid_slide_collision #(
  parameter int MAP_W         = 64,
  parameter int MAP_H         = 64,
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  agsc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output agsc_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [agsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [agsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import agsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  agsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  agsc_dp #(
    .MAP_W         (MAP_W),
    .MAP_H         (MAP_H),
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  // no transaction taken while the map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !in_ready_o)
    else $error("input taken during map clear");

  // a move keeps the input closed on the next cycle
  a_move_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.opcode == OP_MOVE) |=> !in_ready_o)
    else $error("input reopened straight after a move");

  // result register is only loaded when free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // a result appears only from a finished move
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result without a finished move");

endmodule
